/* design/assert_macros.svh */
// Assertion macros shared by the design files.
// Depends on nothing; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* design/nntb_pkg.sv */
// Package for the nearest-neighbor tour builder: payload types, sizes, commands.
// Depends on nothing.
package nntb_pkg;
    localparam int MaxPoints = 32;
    localparam int IdxW = $clog2(MaxPoints);
    localparam int CntW = $clog2(MaxPoints + 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [15:0]        city_label;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
    } t_in;

    typedef struct packed {
        logic [4:0]  position;
        logic [15:0] tour_label;
        logic [16:0] leg_length;
        logic [21:0] running_length;
        logic        is_last;
        logic        error;
    } t_out;

    // Commands from controller to datapath.
    typedef struct packed {
        logic            load;       // write input city at city count
        logic            clr_count;  // clear city count
        logic            rd;         // read cities a and b from store
        logic [IdxW-1:0] rd_a;
        logic [IdxW-1:0] rd_b;
        logic            dist_start; // start distance unit on read data
    } t_cmd;

    typedef struct packed {
        logic [CntW-1:0] count;
        logic            dist_done;
        logic [16:0]     dist_val;
        logic [15:0]     label_a;
    } t_sts;
endpackage

/* design/nearest_neighbor_tour_builder_core.sv */
// Channel | Direction | Handshake          | Payload
// input   | in        | i_valid / o_ready  | nntb_pkg::t_in
// output  | out       | o_valid / i_ready  | nntb_pkg::t_out
// A load transaction writes one city while the store is not full. A run with
// N cities evaluates about N*N/2 + N distances in the shared distance unit
// (absolute value, multiply, sum and a 17-step root), and steps over each
// visited city without starting a distance.
// Reset clears the city count, the controller and the output valid flag.
// A stalled output holds the run where it is.
// Depends on nntb_pkg, nntb_ctrl, nntb_datapath and assert_macros.svh.
`include "assert_macros.svh"
module nearest_neighbor_tour_builder_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  nntb_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output nntb_pkg::t_out o_data
);
    nntb_pkg::t_cmd cmd;
    nntb_pkg::t_sts sts;

    nntb_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_in(i_data), .o_ready,
        .o_valid, .i_ready, .o_out(o_data), .o_cmd(cmd), .i_sts(sts)
    );

    nntb_datapath u_dp (
        .i_clk, .i_rst_n, .i_in(i_data), .i_cmd(cmd), .o_sts(sts)
    );

    `ASSERT_IMPLIES(a_no_accept_busy, i_clk, i_rst_n, o_valid, !o_ready)
    `ASSERT_IMPLIES(a_err_last, i_clk, i_rst_n, o_valid && o_data.error, o_data.is_last)
    `ASSERT_NEXT(a_run_clears, i_clk, i_rst_n, i_valid && o_ready && i_data.opcode, sts.count == '0)
endmodule

/* design/nntb_datapath.sv */
// Datapath: city store memories, squared distance and iterative rounded root.
// Depends on nntb_pkg.
module nntb_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nntb_pkg::t_in   i_in,
    input  nntb_pkg::t_cmd  i_cmd,
    output nntb_pkg::t_sts  o_sts
);
    logic [15:0] r_xs [nntb_pkg::MaxPoints];
    logic [15:0] r_ys [nntb_pkg::MaxPoints];
    logic [15:0] r_ls [nntb_pkg::MaxPoints];
    logic [nntb_pkg::CntW-1:0] r_count;
    logic signed [15:0] r_xa, r_ya, r_xb, r_yb;
    logic [15:0] r_la;
    logic [16:0] r_ux, r_uy;
    logic [33:0] r_sx, r_sy;
    logic [33:0] r_s;
    logic [34:0] r_rem;
    logic [17:0] r_root;
    logic [4:0]  r_step;
    logic [2:0]  r_ph;
    logic [16:0] r_dist;
    logic        r_done;
    logic signed [16:0] dx, dy;
    logic [36:0] trial;
    logic [36:0] rem_sh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_count != nntb_pkg::CntW'(nntb_pkg::MaxPoints)) begin
            r_xs[r_count[nntb_pkg::IdxW-1:0]] <= i_in.coord_x;
            r_ys[r_count[nntb_pkg::IdxW-1:0]] <= i_in.coord_y;
            r_ls[r_count[nntb_pkg::IdxW-1:0]] <= i_in.city_label;
        end
        if (i_cmd.rd) begin
            r_xa <= r_xs[i_cmd.rd_a];
            r_ya <= r_ys[i_cmd.rd_a];
            r_la <= r_ls[i_cmd.rd_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_xb <= r_xs[i_cmd.rd_b];
            r_yb <= r_ys[i_cmd.rd_b];
        end
    end

    assign dx = 17'(r_xa) - 17'(r_xb);
    assign dy = 17'(r_ya) - 17'(r_yb);
    assign rem_sh = {r_rem, r_s[33:32]};
    assign trial  = {17'd0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ph    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.clr_count) begin
                r_count <= '0;
            end else if (i_cmd.load && r_count != nntb_pkg::CntW'(nntb_pkg::MaxPoints)) begin
                r_count <= r_count + 1'b1;
            end
            case (r_ph)
                3'd0: begin
                    if (i_cmd.dist_start) begin
                        r_ph <= 3'd1;
                    end
                end
                3'd1: begin
                    r_ux <= dx[16] ? 17'(-dx) : 17'(dx);
                    r_uy <= dy[16] ? 17'(-dy) : 17'(dy);
                    r_ph <= 3'd2;
                end
                3'd2: begin
                    r_sx <= r_ux * r_ux;
                    r_sy <= r_uy * r_uy;
                    r_ph <= 3'd3;
                end
                3'd3: begin
                    r_s    <= r_sx + r_sy;
                    r_rem  <= '0;
                    r_root <= '0;
                    r_step <= '0;
                    r_ph   <= 3'd4;
                end
                3'd4: begin
                    r_s <= {r_s[31:0], 2'b00};
                    if (rem_sh >= trial) begin
                        r_rem  <= 35'(rem_sh - trial);
                        r_root <= {r_root[16:0], 1'b1};
                    end else begin
                        r_rem  <= 35'(rem_sh);
                        r_root <= {r_root[16:0], 1'b0};
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == 5'd16) begin
                        r_ph <= 3'd5;
                    end
                end
                3'd5: begin
                    r_dist <= (r_rem > 35'(r_root)) ? 17'(r_root + 1'b1) : 17'(r_root);
                    r_done <= 1'b1;
                    r_ph   <= 3'd0;
                end
                default: r_ph <= 3'd0;
            endcase
        end
    end

    assign o_sts.count     = r_count;
    assign o_sts.dist_done = r_done;
    assign o_sts.dist_val  = r_dist;
    assign o_sts.label_a   = r_la;
endmodule

/* design/nntb_ctrl.sv */
// Controller: sequences loads, the nearest-neighbor search and tour emission.
// Depends on nntb_pkg.
module nntb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  nntb_pkg::t_in   i_in,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output nntb_pkg::t_out  o_out,
    output nntb_pkg::t_cmd  o_cmd,
    input  nntb_pkg::t_sts  i_sts
);
    localparam int IW = nntb_pkg::IdxW;
    localparam int CW = nntb_pkg::CntW;

    typedef enum logic [3:0] {
        S_IDLE, S_FREAD, S_FWAIT, S_SREAD, S_SWAIT, S_EADDR, S_EREAD, S_EWAIT, S_OUT
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_n;
    logic [IW-1:0] r_cur, r_j, r_best, r_pos;
    logic [16:0]   r_bestd;
    logic          r_found;
    logic [nntb_pkg::MaxPoints-1:0] r_vis;
    logic [IW-1:0] r_tour [nntb_pkg::MaxPoints];
    logic [IW-1:0] r_ta, r_tb;
    logic [21:0]   r_run;
    logic          r_valid;
    nntb_pkg::t_out r_out;
    logic          accept_in;
    logic          last_j;
    logic [CW-1:0] pos1;

    assign o_ready   = (r_state == S_IDLE) && !r_valid;
    assign accept_in = i_valid && o_ready;
    assign last_j    = (CW'(r_j) + 1'b1 == r_n);
    assign pos1      = CW'(r_pos) + 1'b1;

    always_comb begin
        o_cmd = '0;
        o_cmd.load      = accept_in && i_in.opcode == nntb_pkg::OP_LOAD;
        o_cmd.clr_count = accept_in && i_in.opcode == nntb_pkg::OP_RUN;
        o_cmd.rd_a      = r_cur;
        o_cmd.rd_b      = r_j;
        o_cmd.rd = (r_state == S_FREAD) || (r_state == S_SREAD);
        o_cmd.dist_start = o_cmd.rd;
        if (r_state == S_EREAD) begin
            o_cmd.rd   = 1'b1;
            o_cmd.rd_a = r_ta;
            o_cmd.rd_b = r_tb;
            o_cmd.dist_start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EADDR) begin
            r_ta <= r_tour[r_pos];
            r_tb <= (pos1 == r_n) ? r_tour[0] : r_tour[pos1[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_vis   <= '0;
        end else begin
            if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept_in && i_in.opcode == nntb_pkg::OP_RUN) begin
                        r_n <= i_sts.count;
                        r_vis <= '0;
                        if (i_sts.count < CW'(2)) begin
                            r_out.position       <= '0;
                            r_out.tour_label     <= '0;
                            r_out.leg_length     <= '0;
                            r_out.running_length <= '0;
                            r_out.is_last        <= 1'b1;
                            r_out.error          <= 1'b1;
                            r_valid <= 1'b1;
                        end else begin
                            r_cur <= '0;
                            r_j   <= IW'(1);
                            r_found <= 1'b0;
                            r_state <= S_FREAD;
                        end
                    end
                end
                S_FREAD: r_state <= S_FWAIT;
                S_FWAIT: begin
                    if (i_sts.dist_done) begin
                        if (!r_found || i_sts.dist_val < r_bestd) begin
                            r_bestd <= i_sts.dist_val;
                            r_best  <= r_j;
                        end
                        r_found <= 1'b1;
                        if (last_j) begin
                            r_pos <= '0;
                            r_state <= S_SWAIT;
                            r_j <= '0;
                        end else begin
                            r_j <= r_j + 1'b1;
                            r_state <= S_FREAD;
                        end
                    end
                end
                S_SREAD: r_state <= S_SWAIT;
                S_SWAIT: begin
                    if (r_j == '0 && !o_cmd.rd && r_found) begin
                        // Commit the chosen city and begin the next step.
                        r_tour[r_pos] <= r_best;
                        r_vis[r_best] <= 1'b1;
                        r_cur <= r_best;
                        r_found <= 1'b0;
                        if (pos1 == r_n) begin
                            r_pos <= '0;
                            r_run <= '0;
                            r_state <= S_EADDR;
                        end else begin
                            r_pos <= pos1[IW-1:0];
                            r_j <= '0;
                            r_state <= (r_vis[0] || r_best == '0) ? S_SWAIT : S_SREAD;
                        end
                    end else if (i_sts.dist_done || r_vis[r_j]) begin
                        if (i_sts.dist_done &&
                            (!r_found || i_sts.dist_val < r_bestd)) begin
                            r_bestd <= i_sts.dist_val;
                            r_best  <= r_j;
                        end
                        if (i_sts.dist_done) r_found <= 1'b1;
                        if (last_j) begin
                            r_j <= '0;
                        end else begin
                            r_j <= r_j + 1'b1;
                            r_state <= r_vis[IW'(r_j + 1'b1)] ? S_SWAIT : S_SREAD;
                        end
                    end
                end
                S_EADDR: begin
                    r_state <= S_EREAD;
                end
                S_EREAD: begin
                    r_state <= S_EWAIT;
                end
                S_EWAIT: begin
                    if (i_sts.dist_done) begin
                        r_out.position       <= 5'(r_pos);
                        r_out.tour_label     <= i_sts.label_a;
                        r_out.leg_length     <= i_sts.dist_val;
                        r_out.running_length <= r_run + 22'(i_sts.dist_val);
                        r_out.is_last        <= (pos1 == r_n);
                        r_out.error          <= 1'b0;
                        r_run   <= r_run + 22'(i_sts.dist_val);
                        r_valid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (r_valid && i_ready) begin
                        if (pos1 == r_n) begin
                            r_vis   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_pos   <= pos1[IW-1:0];
                            r_state <= S_EADDR;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;
endmodule
